// ===== rtl/core/framed_packet_receiver_assert.svh =====
// Assertion macros shared by the receiver RTL.
// Needs nothing else; assertions vanish when SYNTH is defined.
`ifndef FRAMED_PACKET_RECEIVER_ASSERT_SVH
`define FRAMED_PACKET_RECEIVER_ASSERT_SVH
`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define FPR_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("receiver assertion failed");
// antecedent implies consequent in the next cycle
`define FPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("receiver assertion failed");
`else
`define FPR_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define FPR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/fpr_pkg.sv =====
// Shared types and constants for the framed packet receiver.
// No dependencies; imported by every module of the block.
package fpr_pkg;

	// register indexes of the configuration port
	localparam int unsigned CfgAddrW = 3;
	typedef enum logic [CfgAddrW-1:0] {
		REG_ENABLE        = 3'd0,
		REG_HEADER_FIRST  = 3'd1,
		REG_HEADER_SECOND = 3'd2,
		REG_HEADER_THIRD  = 3'd3,
		REG_NAME_LIMIT    = 3'd4,
		REG_DATA_LIMIT    = 3'd5
	} cfg_reg_t;

	localparam int unsigned CfgDataW = 16;

	// reset values of the registers
	localparam logic [7:0]  HeaderFirstRst  = 8'd6;
	localparam logic [7:0]  HeaderSecondRst = 8'd134;
	localparam logic [7:0]  HeaderThirdRst  = 8'd247;
	localparam logic [7:0]  NameLimitRst    = 8'd32;
	localparam logic [15:0] DataLimitRst    = 16'd256;

	// parser phases
	typedef enum logic [2:0] {
		PH_WAIT     = 3'd0,
		PH_NAME_LEN = 3'd1,
		PH_NAME     = 3'd2,
		PH_DATA_LEN = 3'd3,
		PH_DATA     = 3'd4,
		PH_CSUM     = 3'd5
	} phase_t;

	// role reported for each byte
	typedef enum logic [2:0] {
		K_NONE     = 3'd0,
		K_NAME     = 3'd1,
		K_DATA     = 3'd2,
		K_HEADER   = 3'd3,
		K_GOOD     = 3'd4,
		K_CSUM_ERR = 3'd5,
		K_ABORT    = 3'd6
	} kind_t;

	typedef struct packed {
		logic        enable;
		logic [7:0]  header_first;
		logic [7:0]  header_second;
		logic [7:0]  header_third;
		logic [7:0]  name_limit;
		logic [15:0] data_limit;
	} cfg_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  byte_value;
		logic [15:0] byte_index;
		logic [7:0]  name_length;
		logic [15:0] data_length;
	} result_t;

endpackage

// ===== rtl/core/fpr_cfg.sv =====
// Configuration register file of the receiver.
// Depends on fpr_pkg.
module fpr_cfg
	import fpr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgAddrW-1:0] cfg_addr,
	input  logic [CfgDataW-1:0] cfg_wdata,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	// write decode; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable        <= 1'b1;
			cfg_q.header_first  <= HeaderFirstRst;
			cfg_q.header_second <= HeaderSecondRst;
			cfg_q.header_third  <= HeaderThirdRst;
			cfg_q.name_limit    <= NameLimitRst;
			cfg_q.data_limit    <= DataLimitRst;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_ENABLE:        cfg_q.enable        <= cfg_wdata[0];
				REG_HEADER_FIRST:  cfg_q.header_first  <= cfg_wdata[7:0];
				REG_HEADER_SECOND: cfg_q.header_second <= cfg_wdata[7:0];
				REG_HEADER_THIRD:  cfg_q.header_third  <= cfg_wdata[7:0];
				REG_NAME_LIMIT:    cfg_q.name_limit    <= cfg_wdata[7:0];
				REG_DATA_LIMIT:    cfg_q.data_limit    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/core/fpr_hdr_det.sv =====
// Three-byte header detector, run on every enabled byte.
// Depends on fpr_pkg.
module fpr_hdr_det
	import fpr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output logic       hdr_done
);

	logic [7:0] first_seen_q, first_seen_d;
	logic [7:0] second_seen_q, second_seen_d;
	logic [1:0] distance_q, distance_d;

	// match tests, first header byte wins
	always_comb begin
		first_seen_d  = first_seen_q;
		second_seen_d = second_seen_q;
		hdr_done      = 1'b0;
		if (rx_byte == cfg.header_first) begin
			first_seen_d = rx_byte;
		end else if (rx_byte == cfg.header_second) begin
			if (first_seen_q == cfg.header_first && distance_q == 2'd1) begin
				second_seen_d = rx_byte;
			end else begin
				first_seen_d = 8'd0;
			end
		end else if (rx_byte == cfg.header_third) begin
			if (distance_q == 2'd2 && second_seen_q == cfg.header_second) begin
				hdr_done = 1'b1;
			end else begin
				first_seen_d  = 8'd0;
				second_seen_d = 8'd0;
			end
		end else begin
			first_seen_d  = 8'd0;
			second_seen_d = 8'd0;
		end
	end

	// distance: set to one by a first byte, held on a full header, else saturating count
	always_comb begin
		if (rx_byte == cfg.header_first) begin
			distance_d = 2'd1;
		end else if (hdr_done || distance_q == 2'd3) begin
			distance_d = distance_q;
		end else begin
			distance_d = distance_q + 2'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_seen_q  <= 8'd0;
			second_seen_q <= 8'd0;
			distance_q    <= 2'd0;
		end else if (step_en) begin
			first_seen_q  <= first_seen_d;
			second_seen_q <= second_seen_d;
			distance_q    <= distance_d;
		end
	end

endmodule

// ===== rtl/core/fpr_parser.sv =====
// Frame field parser with running checksum.
// Depends on fpr_pkg; takes the header strobe from fpr_hdr_det.
module fpr_parser
	import fpr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  logic [7:0] rx_byte,
	input  logic       hdr_done,
	input  cfg_t       cfg,
	output result_t    res
);

	phase_t      phase_q, phase_d;
	logic        step_q, step_d;
	logic [7:0]  nlen_q, nlen_d;
	logic [15:0] pos_q, pos_d;
	logic [15:0] data_len_q, data_len_d;
	logic [15:0] sum_q, sum_d;
	logic [7:0]  sum_high_q, sum_high_d;

	logic [15:0] pos_inc;
	logic [15:0] data_len_full;
	logic [15:0] sum_add;
	logic [15:0] csum_got;

	assign pos_inc       = pos_q + 16'd1;
	assign data_len_full = {data_len_q[15:8], rx_byte};
	assign sum_add       = sum_q + {8'd0, rx_byte};
	assign csum_got      = {sum_high_q, rx_byte};

	// next state
	always_comb begin
		phase_d    = phase_q;
		step_d     = step_q;
		nlen_d     = nlen_q;
		pos_d      = pos_q;
		data_len_d = data_len_q;
		sum_d      = sum_q;
		sum_high_d = sum_high_q;
		if (cfg.enable) begin
			if (hdr_done) begin
				phase_d = PH_NAME_LEN;
				sum_d   = 16'd0;
			end else begin
				case (phase_q)
					PH_NAME_LEN: begin
						nlen_d = rx_byte;
						if (rx_byte > cfg.name_limit) begin
							phase_d = PH_WAIT;
						end else if (rx_byte == 8'd0) begin
							phase_d = PH_DATA_LEN;
							step_d  = 1'b0;
						end else begin
							phase_d = PH_NAME;
							pos_d   = 16'd0;
						end
					end
					PH_NAME: begin
						sum_d = sum_add;
						pos_d = pos_inc;
						if (pos_inc == {8'd0, nlen_q}) begin
							phase_d = PH_DATA_LEN;
							step_d  = 1'b0;
						end
					end
					PH_DATA_LEN: begin
						if (!step_q) begin
							data_len_d = {rx_byte, 8'd0};
							step_d     = 1'b1;
						end else begin
							data_len_d = data_len_full;
							if (data_len_full > cfg.data_limit) begin
								phase_d = PH_WAIT;
							end else if (data_len_full == 16'd0) begin
								phase_d = PH_CSUM;
								step_d  = 1'b0;
							end else begin
								phase_d = PH_DATA;
								pos_d   = 16'd0;
							end
						end
					end
					PH_DATA: begin
						sum_d = sum_add;
						pos_d = pos_inc;
						if (pos_inc == data_len_q) begin
							phase_d = PH_CSUM;
							step_d  = 1'b0;
						end
					end
					PH_CSUM: begin
						if (!step_q) begin
							sum_high_d = rx_byte;
							step_d     = 1'b1;
						end else begin
							phase_d = PH_WAIT;
						end
					end
					default: phase_d = PH_WAIT;
				endcase
			end
		end
	end

	// byte role and result fields
	always_comb begin
		res.kind        = K_NONE;
		res.byte_value  = 8'd0;
		res.byte_index  = 16'd0;
		res.name_length = nlen_d;
		res.data_length = data_len_d;
		if (cfg.enable) begin
			if (hdr_done) begin
				res.kind = K_HEADER;
			end else begin
				case (phase_q)
					PH_NAME_LEN: begin
						if (rx_byte > cfg.name_limit) res.kind = K_ABORT;
					end
					PH_NAME: begin
						res.kind       = K_NAME;
						res.byte_value = rx_byte;
						res.byte_index = pos_q;
					end
					PH_DATA_LEN: begin
						if (step_q && data_len_full > cfg.data_limit) res.kind = K_ABORT;
					end
					PH_DATA: begin
						res.kind       = K_DATA;
						res.byte_value = rx_byte;
						res.byte_index = pos_q;
					end
					PH_CSUM: begin
						if (step_q) res.kind = (csum_got == sum_q) ? K_GOOD : K_CSUM_ERR;
					end
					default: res.kind = K_NONE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_WAIT;
			step_q     <= 1'b0;
			nlen_q     <= 8'd0;
			pos_q      <= 16'd0;
			data_len_q <= 16'd0;
			sum_q      <= 16'd0;
			sum_high_q <= 8'd0;
		end else if (step_en) begin
			phase_q    <= phase_d;
			step_q     <= step_d;
			nlen_q     <= nlen_d;
			pos_q      <= pos_d;
			data_len_q <= data_len_d;
			sum_q      <= sum_d;
			sum_high_q <= sum_high_d;
		end
	end

endmodule

// ===== rtl/core/framed_packet_receiver.sv =====
// Top level of the framed packet receiver: input register, parser, result register.
// Depends on fpr_pkg, fpr_cfg, fpr_hdr_det, fpr_parser and the assertion header.
//
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------------
//  s_*      | in        | tdata: rx_byte
//  m_*      | out       | tdata: byte_value, byte_index, name_length, data_length
//           |           | tuser: kind
//  cfg_*    | in        | write enable, register index, write data
//
// One beat in, one beat out; a new byte is taken every cycle while the output flows.
// A byte passes through the input register, then the result register.
// The header, length and checksum state updates in the same cycle a byte
// moves from the input register to the result register.
// arst_n clears all control state and loads the register reset values.
// A stalled m_tready holds the result; one more byte is still taken into the input register.
`include "framed_packet_receiver_assert.svh"

module framed_packet_receiver
	import fpr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // [7:0] rx_byte
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [47:0]         m_tdata,   // [7:0] byte_value, [23:8] byte_index,
	                                       // [31:24] name_length, [47:32] data_length
	output logic [2:0]          m_tuser,   // [2:0] kind
	input  logic                cfg_we,
	input  logic [CfgAddrW-1:0] cfg_addr,
	input  logic [CfgDataW-1:0] cfg_wdata
);

	cfg_t       cfg;
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       valid_s2;
	result_t    res_s2;
	result_t    res;
	logic       adv;
	logic       hdr_done;
	logic       step_en;

	fpr_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// handshake: stage 1 moves on when the result register is free or being drained
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign step_en  = adv && cfg.enable;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) byte_s1 <= s_tdata;
	end

	fpr_hdr_det u_hdr_det (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (step_en),
		.rx_byte  (byte_s1),
		.cfg      (cfg),
		.hdr_done (hdr_done)
	);

	fpr_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.step_en  (step_en),
		.rx_byte  (byte_s1),
		.hdr_done (hdr_done),
		.cfg      (cfg),
		.res      (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) res_s2 <= res;
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = res_s2.kind;
	assign m_tdata  = {res_s2.data_length, res_s2.name_length,
		res_s2.byte_index, res_s2.byte_value};

	// checks
	`FPR_ASSERT_SAME(a_hold_full, clk, arst_n, valid_s1 && !adv, !s_tready)
	`FPR_ASSERT_NEXT(a_take_lands, clk, arst_n, s_tvalid && s_tready, valid_s1)
	`FPR_ASSERT_SAME(a_name_idx, clk, arst_n, m_tvalid && m_tuser == K_NAME,
		m_tdata[23:8] < {8'd0, m_tdata[31:24]})
	`FPR_ASSERT_SAME(a_data_idx, clk, arst_n, m_tvalid && m_tuser == K_DATA,
		m_tdata[23:8] < m_tdata[47:32])

endmodule

// ===== tb/fpr_frame_checker.sv =====
// Frame checker for the framed packet receiver: mirrors the register writes, predicts
// the role and fields reported for every accepted byte and compares them with each result beat.
// Depends on fpr_pkg only.
module fpr_frame_checker
	import fpr_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [7:0]          s_tdata,      // [7:0] rx_byte
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [47:0]         m_tdata,      // [7:0] byte_value, [23:8] byte_index,
	                                          // [31:24] name_length, [47:32] data_length
	input  logic [2:0]          m_tuser,      // [2:0] kind
	input  logic                cfg_we,
	input  logic [CfgAddrW-1:0] cfg_addr,
	input  logic [CfgDataW-1:0] cfg_wdata,
	output int                  errors,
	output int                  outstanding
);

	// mirrored registers and parser state
	cfg_t        regs;
	logic [7:0]  first_seen;
	logic [7:0]  second_seen;
	logic [1:0]  hdr_dist;
	phase_t      ph;
	logic        low_next;
	logic [7:0]  cur_nlen;
	logic [15:0] pos;
	logic [15:0] data_len;
	logic [15:0] sum;
	logic [7:0]  sum_hi;

	// byte reports still owed by the block, oldest first
	result_t     reports_due [$];

	function automatic int field_diff(string field, int unsigned want, int unsigned got);
		if (want == got) return 0;
		$error("%s: expected %0d, got %0d", field, want, got);
		return 1;
	endfunction

	// one byte through header detection and the frame parser
	task automatic parse_byte(input logic [7:0] b, output result_t r);
		logic        hdr_done;
		logic [15:0] got;
		hdr_done = 1'b0;
		r = '0;
		if (regs.enable) begin
			// header tests in the order first, second, third
			if (b == regs.header_first) begin
				first_seen = b;
				hdr_dist = 2'd0;
			end else if (b == regs.header_second) begin
				if (first_seen == regs.header_first && hdr_dist == 2'd1) second_seen = b;
				else first_seen = 8'd0;
			end else if (b == regs.header_third) begin
				if (hdr_dist == 2'd2 && second_seen == regs.header_second) begin
					hdr_done = 1'b1;
				end else begin
					second_seen = 8'd0;
					first_seen = 8'd0;
				end
			end else begin
				second_seen = 8'd0;
				first_seen = 8'd0;
			end

			if (hdr_done) begin
				// distance stays at two, so a repeated third byte matches again
				ph = PH_NAME_LEN;
				sum = 16'd0;
				r.kind = K_HEADER;
			end else begin
				if (hdr_dist != 2'd3) hdr_dist++;
				case (ph)
				PH_NAME_LEN: begin
					cur_nlen = b;
					if (b > regs.name_limit) begin
						ph = PH_WAIT;
						r.kind = K_ABORT;
					end else if (b == 8'd0) begin
						ph = PH_DATA_LEN;
						low_next = 1'b0;
					end else begin
						ph = PH_NAME;
						pos = 16'd0;
					end
				end
				PH_NAME: begin
					r.kind = K_NAME;
					r.byte_value = b;
					r.byte_index = pos;
					sum += b;
					pos++;
					if (pos == {8'd0, cur_nlen}) begin
						ph = PH_DATA_LEN;
						low_next = 1'b0;
					end
				end
				PH_DATA_LEN: begin
					if (!low_next) begin
						data_len = {b, 8'd0};
						low_next = 1'b1;
					end else begin
						data_len = data_len | b;
						if (data_len > regs.data_limit) begin
							ph = PH_WAIT;
							r.kind = K_ABORT;
						end else if (data_len == 16'd0) begin
							ph = PH_CSUM;
							low_next = 1'b0;
						end else begin
							ph = PH_DATA;
							pos = 16'd0;
						end
					end
				end
				PH_DATA: begin
					r.kind = K_DATA;
					r.byte_value = b;
					r.byte_index = pos;
					sum += b;
					pos++;
					if (pos == data_len) begin
						ph = PH_CSUM;
						low_next = 1'b0;
					end
				end
				PH_CSUM: begin
					if (!low_next) begin
						sum_hi = b;
						low_next = 1'b1;
					end else begin
						got = {sum_hi, b};
						r.kind = (got == sum) ? K_GOOD : K_CSUM_ERR;
						ph = PH_WAIT;
					end
				end
				default: ph = PH_WAIT;
				endcase
			end
		end
		r.name_length = cur_nlen;
		r.data_length = data_len;
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		result_t want;
		int      bad;
		if (!arst_n) begin
			regs = '{1'b1, HeaderFirstRst, HeaderSecondRst, HeaderThirdRst,
				NameLimitRst, DataLimitRst};
			first_seen = 8'd0;
			second_seen = 8'd0;
			hdr_dist = 2'd0;
			ph = PH_WAIT;
			low_next = 1'b0;
			cur_nlen = 8'd0;
			pos = 16'd0;
			data_len = 16'd0;
			sum = 16'd0;
			sum_hi = 8'd0;
			reports_due.delete();
			errors <= 0;
			outstanding <= 0;
		end else begin
			bad = 0;

			// result beat against the oldest prediction
			if (m_tvalid && m_tready) begin
				if (reports_due.size() == 0) begin
					$error("result beat with no byte waiting for it");
					bad++;
				end else begin
					want = reports_due.pop_front();
					bad += field_diff("kind", want.kind, m_tuser);
					bad += field_diff("byte_value", want.byte_value, m_tdata[7:0]);
					bad += field_diff("byte_index", want.byte_index, m_tdata[23:8]);
					bad += field_diff("name_length", want.name_length, m_tdata[31:24]);
					bad += field_diff("data_length", want.data_length, m_tdata[47:32]);
				end
			end

			// input beat
			if (s_tvalid && s_tready) begin
				parse_byte(s_tdata, want);
				reports_due.push_back(want);
			end

			// register write
			if (cfg_we) begin
				case (cfg_reg_t'(cfg_addr))
				REG_ENABLE:        regs.enable = cfg_wdata[0];
				REG_HEADER_FIRST:  regs.header_first = cfg_wdata[7:0];
				REG_HEADER_SECOND: regs.header_second = cfg_wdata[7:0];
				REG_HEADER_THIRD:  regs.header_third = cfg_wdata[7:0];
				REG_NAME_LIMIT:    regs.name_limit = cfg_wdata[7:0];
				REG_DATA_LIMIT:    regs.data_limit = cfg_wdata;
				default: ;
				endcase
			end

			errors <= errors + bad;
			outstanding <= reports_due.size();
		end
	end

endmodule

// ===== tb/tb_framed_packet_receiver.sv =====
// Testbench top for the framed packet receiver: drives bytes, output stalls and
// register writes, and gives the verdict from the frame checker's error count.
// Depends on fpr_pkg, framed_packet_receiver and fpr_frame_checker.
module tb_framed_packet_receiver;
	import fpr_pkg::*;

	localparam int QuietLimit    = 200;
	localparam int BytesPerPhase = 290;
	localparam int PhaseCount    = 6;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [7:0]          s_tdata = 8'd0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [47:0]         m_tdata;
	logic [2:0]          m_tuser;
	logic                cfg_we = 1'b0;
	logic [CfgAddrW-1:0] cfg_addr = REG_ENABLE;
	logic [CfgDataW-1:0] cfg_wdata = '0;

	int   errors;
	int   outstanding;
	cfg_t regs;            // settings as last written, for building frames
	bit   calm = 1'b0;     // no idling on either side
	int   hold = 0;
	int   quiet = 0;
	int   bytes_sent = 0;

	framed_packet_receiver uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata)
	);

	fpr_frame_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always #2 clk = ~clk;

	// output stalls in bursts of random length
	always @(posedge clk) begin
		if (hold > 0) begin
			hold = hold - 1;
			m_tready <= 1'b0;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			hold = $urandom_range(0, 3);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog: too long without any beat or write
	always @(posedge clk) begin
		if (!arst_n || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else if (quiet == QuietLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// one byte beat, sometimes after a random gap
	task automatic push_byte(input logic [7:0] b);
		if (!calm && $urandom_range(0, 6) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		do @(posedge clk); while (!s_tready);
		bytes_sent++;
	endtask

	task automatic send_header();
		push_byte(regs.header_first);
		push_byte(regs.header_second);
		push_byte(regs.header_third);
	endtask

	// whole frame; fill < 0 gives random content, else every name and data byte is fill
	task automatic send_frame(input int nlen, input int dlen, input bit bad_sum, input int fill);
		logic [15:0] total;
		logic [7:0]  b;
		total = 16'd0;
		send_header();
		push_byte(nlen[7:0]);
		for (int i = 0; i < nlen; i++) begin
			b = (fill < 0) ? 8'($urandom) : fill[7:0];
			total += b;
			push_byte(b);
		end
		push_byte(dlen[15:8]);
		push_byte(dlen[7:0]);
		for (int i = 0; i < dlen; i++) begin
			b = (fill < 0) ? 8'($urandom) : fill[7:0];
			total += b;
			push_byte(b);
		end
		if (bad_sum) total ^= 16'(1 << $urandom_range(0, 15));
		push_byte(total[15:8]);
		push_byte(total[7:0]);
	endtask

	// all six registers, one write per cycle
	task automatic program_regs(input cfg_t c);
		cfg_we <= 1'b1;
		cfg_addr <= REG_ENABLE;
		cfg_wdata <= CfgDataW'(c.enable);
		@(posedge clk);
		cfg_addr <= REG_HEADER_FIRST;
		cfg_wdata <= CfgDataW'(c.header_first);
		@(posedge clk);
		cfg_addr <= REG_HEADER_SECOND;
		cfg_wdata <= CfgDataW'(c.header_second);
		@(posedge clk);
		cfg_addr <= REG_HEADER_THIRD;
		cfg_wdata <= CfgDataW'(c.header_third);
		@(posedge clk);
		cfg_addr <= REG_NAME_LIMIT;
		cfg_wdata <= CfgDataW'(c.name_limit);
		@(posedge clk);
		cfg_addr <= REG_DATA_LIMIT;
		cfg_wdata <= c.data_limit;
		@(posedge clk);
		cfg_we <= 1'b0;
		regs = c;
	endtask

	// stop sending and wait until every byte has been reported
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (4) @(posedge clk);
	endtask

	// mostly well-formed frames, plus aborts, cut frames, header fragments and noise
	task automatic random_traffic(input int target);
		int start;
		int pick;
		int nmax;
		int dmax;
		int n;
		start = bytes_sent;
		while (bytes_sent - start < target) begin
			nmax = (regs.name_limit < 6) ? regs.name_limit : 6;
			dmax = (regs.data_limit < 10) ? regs.data_limit : 10;
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				send_frame($urandom_range(0, nmax), $urandom_range(0, dmax),
					$urandom_range(0, 9) == 0, -1);
			end else if (pick < 63) begin
				// a length over its limit aborts the frame
				if ($urandom_range(0, 1) == 1 && regs.name_limit != 8'hFF) begin
					send_header();
					push_byte(8'($urandom_range(regs.name_limit + 1, 255)));
				end else if (regs.data_limit != 16'hFFFF) begin
					n = $urandom_range(regs.data_limit + 1, 65535);
					send_header();
					push_byte(8'd0);
					push_byte(n[15:8]);
					push_byte(n[7:0]);
				end else begin
					push_byte(8'($urandom));
				end
			end else if (pick < 73) begin
				// frame cut short; what follows restarts it or runs on
				send_header();
				push_byte(8'($urandom_range(0, nmax)));
				repeat ($urandom_range(0, 4)) push_byte(8'($urandom));
			end else if (pick < 80) begin
				// header fragments and repeated header bytes
				repeat ($urandom_range(2, 6)) begin
					case ($urandom_range(0, 3))
					0: push_byte(regs.header_first);
					1: push_byte(regs.header_second);
					2: push_byte(regs.header_third);
					default: push_byte(8'($urandom));
					endcase
				end
			end else if (pick < 82) begin
				// largest frame of all ones (data capped), so the sum can wrap
				send_frame(regs.name_limit, (regs.data_limit < 300) ? regs.data_limit : 300,
					$urandom_range(0, 1) == 1, 8'hFF);
			end else begin
				repeat ($urandom_range(1, 8)) push_byte(8'($urandom));
			end
		end
	endtask

	initial begin
		cfg_t plan [PhaseCount];
		regs = '{1'b1, HeaderFirstRst, HeaderSecondRst, HeaderThirdRst,
			NameLimitRst, DataLimitRst};
		// zero first header byte and widest limits
		plan[0] = '{1'b1, 8'h00, 8'h11, 8'h22, 8'hFF, 16'hFFFF};
		// zero second header byte, limits at zero
		plan[1] = '{1'b1, 8'h5A, 8'h00, 8'hC3, 8'h00, 16'h0000};
		plan[2] = '{1'b0, HeaderFirstRst, HeaderSecondRst, HeaderThirdRst,
			NameLimitRst, DataLimitRst};
		plan[3] = '{1'b1, 8'hFF, 8'hFE, 8'hFD, 8'h01, 16'h0001};
		plan[4] = '{1'b1, 8'($urandom), 8'($urandom), 8'($urandom),
			8'($urandom_range(0, 40)), 16'($urandom_range(0, 300))};
		plan[5] = '{1'b1, HeaderFirstRst, HeaderSecondRst, HeaderThirdRst,
			NameLimitRst, DataLimitRst};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero-length fields, then one-byte fields at both byte extremes
		send_frame(0, 0, 1'b0, 0);
		send_frame(1, 1, 1'b0, 8'hFF);
		send_frame(1, 1, 1'b1, 8'h00);
		// name length over the limit, then data length over the limit
		send_header();
		push_byte(8'd33);
		send_header();
		push_byte(8'd0);
		push_byte(8'h01);
		push_byte(8'h01);
		// repeated third header byte, then a new header inside a name
		send_header();
		push_byte(regs.header_third);
		push_byte(8'd2);
		push_byte(8'h41);
		send_frame(1, 0, 1'b0, 8'h80);

		for (int p = 0; p < PhaseCount; p++) begin
			settle();
			if (p == PhaseCount - 1) calm = 1'b1;
			program_regs(plan[p]);
			random_traffic(plan[p].enable ? BytesPerPhase : 60);
			// leave a frame open across the next register change
			send_header();
			push_byte(8'd0);
		end
		settle();

		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
